// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: always");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/tlvp_pkg.sv
// Package: types, constants and helpers of the TLV entry stream parser.
package tlvp_pkg;

    localparam int POSITION_BITS_DEFAULT = 8;

    localparam int OUT_TDATA_BITS = 104;
    localparam int OUT_TUSER_BITS = 2;

    localparam logic [5:0] TYPE_STRUCT = 6'd1;
    localparam logic [5:0] TYPE_PACKET = 6'd2;
    localparam logic [5:0] TYPE_BYTES  = 6'd3;

    typedef enum logic [1:0] {
        PH_HDR0,
        PH_HDR1,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic [7:0]         entry_offset;
        logic [4:0]         first_letter;
        logic [4:0]         second_letter;
        logic [5:0]         type_code;
        logic [8:0]         payload_length;
        logic signed [63:0] int_value;
        logic               is_integer;
        logic               truncated;
    } tlvp_result_t;

    function automatic logic is_long_int(input logic [5:0] t);
        return (t[5:4] == 2'b01);
    endfunction

    function automatic logic is_short_int(input logic [5:0] t);
        return t[5];
    endfunction

    function automatic logic has_length_byte(input logic [5:0] t);
        return (t == TYPE_STRUCT) || (t == TYPE_PACKET) || (t == TYPE_BYTES);
    endfunction

    // Payload length of types whose length follows from the type alone.
    function automatic logic [8:0] fixed_length(input logic [5:0] t);
        logic [8:0] len;
        len = 9'd0;
        if (t[5])
            len = 9'd0;
        else if (t[4])
            len = 9'(t[2:0]) + 9'd1;
        else if (t[3])
            len = 9'(t[2:0]);
        else if (t[2] && (t[1:0] != 2'b00))
            len = 9'd1 << t[1:0];
        else
            len = 9'd0;
        return len;
    endfunction

endpackage

// File: rtl/tlvp_parser.sv
// Entry parser: per-byte state machine and result formation.
module tlvp_parser #(
    parameter int POSITION_BITS = tlvp_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output logic                  res_valid,
    output tlvp_pkg::tlvp_result_t res
);
    import tlvp_pkg::*;

    phase_t                   phase_reg, phase_next, phase_step;
    logic [POSITION_BITS-1:0] position_reg, position_next;
    logic [7:0]               start_reg, start_next;
    logic [9:0]               letters_reg, letters_next;
    logic [5:0]               type_reg, type_next;
    logic [8:0]               left_reg, left_next, left_step;
    logic [8:0]               known_reg, known_next;
    logic [63:0]              acc_reg, acc_next, acc_step;
    logic [2:0]               idx_reg, idx_next, idx_step;
    logic                     done;
    logic [63:0]              value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            position_reg <= '0;
            start_reg    <= '0;
            letters_reg  <= '0;
            type_reg     <= '0;
            left_reg     <= '0;
            known_reg    <= '0;
            acc_reg      <= '0;
            idx_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            start_reg    <= start_next;
            letters_reg  <= letters_next;
            type_reg     <= type_next;
            left_reg     <= left_next;
            known_reg    <= known_next;
            acc_reg      <= acc_next;
            idx_reg      <= idx_next;
        end
    end

    always_comb
    begin
        phase_step   = phase_reg;
        start_next   = start_reg;
        letters_next = letters_reg;
        type_next    = type_reg;
        left_step    = left_reg;
        known_next   = known_reg;
        acc_step     = acc_reg;
        idx_step     = idx_reg;
        done         = 1'b0;

        case (phase_reg)
            PH_HDR0:
            begin
                start_next   = position_reg[7:0];
                letters_next = {5'd0, data_byte[4:0]};
                type_next    = {3'd0, data_byte[7:5]};
                acc_step     = '0;
                idx_step     = '0;
                known_next   = '0;
                left_step    = '0;
                phase_step   = PH_HDR1;
            end
            PH_HDR1:
            begin
                letters_next = {data_byte[4:0], letters_reg[4:0]};
                type_next    = {data_byte[7:5], type_reg[2:0]};
                if (has_length_byte(type_next))
                    phase_step = PH_LEN;
                else
                begin
                    known_next = fixed_length(type_next);
                    left_step  = known_next;
                    if (known_next == 9'd0)
                        done = 1'b1;
                    else
                        phase_step = PH_BODY;
                end
            end
            PH_LEN:
            begin
                if (type_reg == TYPE_BYTES)
                    known_next = 9'(data_byte) + 9'd1;
                else if (data_byte == 8'd0)
                    known_next = 9'd1;
                else
                    known_next = 9'(data_byte);
                left_step = known_next - 9'd1;
                if (left_step == 9'd0)
                    done = 1'b1;
                else
                    phase_step = PH_BODY;
            end
            default:
            begin
                if (is_long_int(type_reg))
                begin
                    for (int k = 0; k < 8; k++)
                        if (idx_reg == 3'(k))
                            acc_step[8*k +: 8] = acc_reg[8*k +: 8] | data_byte;
                    idx_step = idx_reg + 3'd1;
                end
                left_step = left_reg - 9'd1;
                if (left_step == 9'd0)
                    done = 1'b1;
            end
        endcase

        if (done)
            phase_step = PH_HDR0;

        position_next = position_reg + POSITION_BITS'(1);
        phase_next    = phase_step;
        left_next     = left_step;
        acc_next      = acc_step;
        idx_next      = idx_step;
        if (last_byte)
        begin
            phase_next    = PH_HDR0;
            position_next = '0;
            left_next     = '0;
            acc_next      = '0;
            idx_next      = '0;
        end
    end

    // Long integers are sign-and-magnitude: negate when type bit 3 is set.
    always_comb
    begin
        value = '0;
        if (is_short_int(type_next))
            value = 64'(type_next[4:0]);
        else if (is_long_int(type_next))
            value = type_next[3] ? (64'd0 - acc_step) : acc_step;
    end

    always_comb
    begin
        res_valid          = done || last_byte;
        res.entry_offset   = start_next;
        res.first_letter   = letters_next[4:0];
        res.second_letter  = letters_next[9:5];
        res.type_code      = type_next;
        res.truncated      = !done;
        if (done)
        begin
            res.payload_length = known_next;
            res.int_value      = value;
            res.is_integer     = is_short_int(type_next) || is_long_int(type_next);
        end
        else
        begin
            res.payload_length = (phase_step == PH_BODY) ? known_next : 9'd0;
            res.int_value      = '0;
            res.is_integer     = 1'b0;
        end
    end

endmodule

// File: rtl/tlv_entry_stream_parser_core.sv
// Top level: TLV entry stream parser with registered input and output stages.
//
// Usage
//   s_axis: one byte of the packet entry area per transfer; tlast marks the
//   final byte of the area, after which parsing restarts at offset zero.
//   m_axis: one transfer per completed entry, or one with the truncated flag
//   when the area ends part-way through an entry.
//   Path: input register, then result register; m_axis_tvalid rises when the
//   result of the byte that completes the entry is loaded into the result register.
//   Throughput: one byte per cycle unless m_axis stalls; the per-byte state
//   update and the 64-bit value negate sit between the input and result registers.
//   Reset: parser state returns to the first header byte at offset zero and
//   both stages empty.
//   Stall: while m_axis_tready is low a waiting result holds; one more byte
//   may be taken into the input register, then s_axis_tready drops.
module tlv_entry_stream_parser_core #(
    parameter int POSITION_BITS = tlvp_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // data_byte
    input  logic                                  s_axis_tlast,  // last_byte
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // entry_offset, first_letter, second_letter, type_code, payload_length,
    // int_value, zero pad
    output logic [tlvp_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
    output logic [tlvp_pkg::OUT_TUSER_BITS-1:0]   m_axis_tuser   // is_integer, truncated
);
    import tlvp_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_data_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    tlvp_result_t out_reg;
    logic         out_free;
    logic         step;
    logic         res_valid;
    tlvp_result_t res;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    tlvp_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= step && res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.int_value, out_reg.payload_length,
                            out_reg.type_code, out_reg.second_letter,
                            out_reg.first_letter, out_reg.entry_offset};
    assign m_axis_tuser  = {out_reg.truncated, out_reg.is_integer};

endmodule

// File: rtl/tlvp_checker.sv
// Port-level checker for the TLV entry stream parser, bound to the top level.
`include "assert_macros.svh"

module tlvp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [tlvp_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input logic [tlvp_pkg::OUT_TUSER_BITS-1:0] m_axis_tuser
);
    import tlvp_pkg::*;

    `ASSERT_NEXT(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `ASSERT_IMPLIES(a_trunc_not_int, clk, rst_n, m_axis_tvalid && m_axis_tuser[1],
        !m_axis_tuser[0])
    `ASSERT_IMPLIES(a_nonint_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata[96:33] == 64'd0)
    `ASSERT_IMPLIES(a_length_range, clk, rst_n, m_axis_tvalid,
        m_axis_tdata[32:24] <= 9'd256)
    `ASSERT_IMPLIES(a_short_int, clk, rst_n, m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[23],
        (m_axis_tdata[96:33] == 64'(m_axis_tdata[22:18])) && (m_axis_tdata[32:24] == 9'd0))

endmodule

bind tlv_entry_stream_parser_core tlvp_checker u_tlvp_checker (.*);
